/* hw/rtl/vce_pkg.sv */
// Shared constants, types and helper functions of the video cadence estimator.
package vce_pkg;

  localparam int TIME_W    = 20;            // time fields in microseconds
  localparam int T_W       = 24;            // configuration registers
  localparam int ENTRY_W   = 8;             // pattern entry width
  localparam int MAX_LEN   = 5;             // longest cadence pattern
  localparam int LEN_W     = 3;             // pattern length 0..MAX_LEN
  localparam int HOLD_W    = 17;            // hysteresis hold counter
  localparam int K_W       = TIME_W + LEN_W; // numerator k of k/n
  localparam int DIV_W     = 48;            // divider operand width
  localparam int MUL_A_W   = 44;
  localparam int MUL_B_W   = 25;
  localparam int P_W       = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = K_W + 7;       // signed expansion accumulators
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  localparam logic [T_W-1:0]    HYST_RESET = T_W'(100000);
  localparam logic [HOLD_W-1:0] HOLD_MAX   = {HOLD_W{1'b1}};
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};

  // Rate and error scale factors
  localparam int VAR_SCALE  = 100;
  localparam int VAR_SET    = 55;
  localparam int VAR_CLEAR  = 45;
  localparam int JUMP_SCALE = 10;
  localparam int ERR_SCALE  = 100;
  localparam int ERR_KEEP   = 99;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DRIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HYST      = 2'd1;

  typedef logic [MAX_LEN-1:0][ENTRY_W-1:0] pat_t;

  typedef enum logic [5:0] {
    S_IDLE, S_PRE, S_CDIV, S_CWAIT,
    S_NF, S_NFT, S_LO, S_LOD, S_LOW, S_HI, S_HID, S_HIW,
    S_KD, S_KW, S_KR, S_EN, S_E1, S_E2, S_E3, S_NEXT,
    S_FB1, S_FB2, S_FB3, S_FB4,
    S_QD, S_QW, S_QN, S_QN2, S_EXP,
    S_CMP, S_HOLD, S_HOLD2, S_DONE
  } vce_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [P_W-1:0] abs_diff(input logic [P_W-1:0] a,
                                              input logic [P_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [ENTRY_W-1:0] sat_entry(input logic [K_W:0] v);
    return (v > (K_W+1)'(ENTRY_MAX)) ? ENTRY_MAX : v[ENTRY_W-1:0];
  endfunction

endpackage

/* hw/rtl/video_cadence_estimator_unit.sv */
// Top level of the video cadence estimator: handshakes, sequencer and state.
//
// Usage: each transfer on the s_axis channel is one update carrying the render
// interval, frame duration, duration deviation and allowed drift. For every
// update exactly one result leaves on m_axis: the changed flag in tuser and
// the active cadence pattern (length and five entries) in tdata.
// The cfg channel writes min_time_until_drift (index 0) and hysteresis_time
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. One update at a time: a new
// update is accepted only once the result of the last one is registered.
// Under variable rate no division is made; when the drift is at or above the
// limit there is one division; the full search tries pattern lengths 1 to 5
// with up to three divisions each through one 48-step restoring divider and
// steps on the shared multiplier, then one more division and the expansion
// of up to five entries. s_axis_tready is high only in the idle state, which
// is entered as the result is registered. Reset (rst, synchronous) clears
// the cadence state and loads the register defaults. A stalled receiver holds
// the result in the output register; the next update is still accepted and
// its result waits until that one leaves.
module video_cadence_estimator_unit import vce_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // refresh_period, frame_period, duration_deviation, max_drift (20 b each)
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pattern_length (3 b), entry_0 .. entry_4 (8 b each), zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // changed (1 b)
  output logic                   m_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [T_W-1:0]         cfg_data
);

  vce_state_t state, state_next;

  // Configuration and cadence state
  logic [T_W-1:0]    min_drift_time, hyst_time;
  logic [TIME_W-1:0] prev_interval;
  pat_t              active_pat, pend_pat, new_pat;
  logic [LEN_W-1:0]  active_len, pend_len, new_len;
  logic [HOLD_W-1:0] hold_count;
  logic              var_rate, jumped, changed;

  // Update operands and search scratch
  logic [TIME_W-1:0] render, frame, dev, drift;
  logic [TIME_W-1:0] cad, err, best_err, fb_err;
  logic [LEN_W-1:0]  n, best_n, idx;
  logic [K_W-1:0]    nf, k, best_k, q, qn;
  logic [K_W+1:0]    thr;
  logic [DIV_W-1:0]  nft, lo;
  logic [P_W-1:0]    lhs;
  logic              best_inf;
  logic signed [ACC_W-1:0] tgt, acc;

  // Shared units
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [P_W-1:0]     mul_p;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  vce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));
  vce_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  logic in_xfer, out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Rate detector and interval jump
  logic [TIME_W+6:0] d_scaled, r_set, r_clear;
  logic [TIME_W+3:0] diff_scaled;
  logic              var_next, jump_now;
  assign d_scaled    = (TIME_W+7)'(dev) * (TIME_W+7)'(VAR_SCALE);
  assign r_set       = (TIME_W+7)'(render) * (TIME_W+7)'(VAR_SET);
  assign r_clear     = (TIME_W+7)'(render) * (TIME_W+7)'(VAR_CLEAR);
  assign diff_scaled = (TIME_W+4)'(abs_diff(P_W'(prev_interval), P_W'(render)))
                       * (TIME_W+4)'(JUMP_SCALE);
  assign jump_now    = (prev_interval != '0) &&
                       (diff_scaled > (TIME_W+4)'(prev_interval));
  always_comb begin
    var_next = var_rate;
    if (d_scaled > r_set) begin
      var_next = 1'b1;
    end else if (d_scaled < r_clear) begin
      var_next = 1'b0;
    end
  end

  // Pattern comparisons
  logic same_active, same_pend;
  assign same_active = (new_len == active_len) && (new_pat == active_pat);
  assign same_pend   = (new_len == pend_len) && (new_pat == pend_pat);

  // Even spreading of k over n frames
  logic signed [ACC_W-1:0] tgt_next, cur;
  logic                    plus;
  logic [K_W:0]            entry_val;
  assign tgt_next  = tgt + ACC_W'(best_k);
  assign cur       = tgt_next - acc;
  assign plus      = ((idx == '0) && (best_k < K_W'(best_n))) ||
                     ((cur <<< 1) >= $signed(ACC_W'(thr)));
  assign entry_val = {1'b0, q} + (K_W+1)'(plus);

  logic [P_W-1:0] err_now;
  assign err_now = abs_diff(mul_p, P_W'(nf));

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and divider requests
  always_comb begin
    state_next  = state;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;
    case (state)
      S_IDLE:  if (in_xfer) state_next = S_PRE;
      S_PRE:   state_next = var_next ? S_DONE : S_CDIV;
      S_CDIV: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({frame, 1'b0}) + DIV_W'(render);
        div_req.den   = DIV_W'({render, 1'b0});
        state_next    = S_CWAIT;
      end
      S_CWAIT: begin
        if (div_rsp.done) begin
          state_next = ((T_W+1)'(drift) >= (T_W+1)'(min_drift_time)) ? S_CMP : S_NF;
        end
      end
      S_NF: begin
        mul_a = MUL_A_W'(frame);
        mul_b = MUL_B_W'(n);
        state_next = S_NFT;
      end
      S_NFT: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'(min_drift_time);
        state_next = S_LO;
      end
      S_LO: begin
        mul_a = MUL_A_W'(min_drift_time) + MUL_A_W'(drift);
        mul_b = MUL_B_W'(render);
        state_next = S_LOD;
      end
      S_LOD: begin
        div_req.start = 1'b1;
        div_req.num   = nft;
        div_req.den   = mul_p[DIV_W-1:0];
        state_next    = S_LOW;
      end
      S_LOW:   if (div_rsp.done) state_next = S_HI;
      S_HI: begin
        mul_a = MUL_A_W'(min_drift_time) - MUL_A_W'(drift);
        mul_b = MUL_B_W'(render);
        state_next = S_HID;
      end
      S_HID: begin
        div_req.start = 1'b1;
        div_req.num   = nft;
        div_req.den   = mul_p[DIV_W-1:0];
        state_next    = S_HIW;
      end
      S_HIW: begin
        if (div_rsp.done) begin
          state_next = (lo < div_rsp.quot) ? S_KD : S_NEXT;
        end
      end
      S_KD: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({nf, 1'b0}) + DIV_W'(render);
        div_req.den   = DIV_W'({render, 1'b0});
        state_next    = S_KW;
      end
      S_KW:    if (div_rsp.done) state_next = S_KR;
      S_KR: begin
        mul_a = MUL_A_W'(k);
        mul_b = MUL_B_W'(render);
        state_next = S_EN;
      end
      S_EN: begin
        if (best_n == '0 || k == '0 || best_inf) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_E1;
        end
      end
      S_E1: begin
        mul_a = MUL_A_W'(best_k);
        mul_b = MUL_B_W'(err);
        state_next = S_E2;
      end
      S_E2: begin
        mul_a = MUL_A_W'(best_err);
        mul_b = MUL_B_W'(k);
        state_next = S_E3;
      end
      S_E3:    state_next = S_NEXT;
      S_NEXT: begin
        if (n == LEN_W'(MAX_LEN)) begin
          state_next = (best_n == '0) ? S_FB1 : S_QD;
        end else begin
          state_next = S_NF;
        end
      end
      S_FB1: begin
        mul_a = MUL_A_W'(cad);
        mul_b = MUL_B_W'(render);
        state_next = S_FB2;
      end
      S_FB2: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = MUL_B_W'(drift);
        state_next = S_FB3;
      end
      S_FB3: begin
        mul_a = MUL_A_W'(fb_err);
        mul_b = MUL_B_W'(min_drift_time);
        state_next = S_FB4;
      end
      S_FB4:   state_next = S_CMP;
      S_QD: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(best_k);
        div_req.den   = DIV_W'(best_n);
        state_next    = S_QW;
      end
      S_QW:    if (div_rsp.done) state_next = S_QN;
      S_QN: begin
        mul_a = MUL_A_W'(q);
        mul_b = MUL_B_W'(best_n);
        state_next = S_QN2;
      end
      S_QN2:   state_next = S_EXP;
      S_EXP:   if (idx == best_n - 1'b1) state_next = S_CMP;
      S_CMP: begin
        if (same_active || jumped) begin
          state_next = S_DONE;
        end else if (same_pend || (hyst_time <= T_W'(render))) begin
          state_next = S_HOLD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_HOLD: begin
        mul_a = MUL_A_W'(hold_count);
        mul_b = MUL_B_W'(render);
        state_next = S_HOLD2;
      end
      S_HOLD2: state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration and cadence state; reset loads their defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      min_drift_time <= '0;
      hyst_time      <= HYST_RESET;
      prev_interval  <= '0;
      active_pat     <= '0;
      active_len     <= '0;
      pend_pat       <= '0;
      pend_len       <= '0;
      hold_count     <= '0;
      var_rate       <= 1'b0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_DRIFT: min_drift_time <= cfg_data;
          CFG_HYST:      hyst_time      <= cfg_data;
          default: ;
        endcase
      end
      // Present a finished result, or drop the one just transferred
      if (state == S_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_PRE: begin
          prev_interval <= render;
          var_rate      <= var_next;
          if (var_next) begin
            hold_count <= '0;
            active_pat <= '0;
            active_len <= '0;
          end
        end
        S_CMP: begin
          if (same_active) begin
            hold_count <= '0;
          end else if (jumped) begin
            active_pat <= new_pat;
            active_len <= new_len;
          end else if (same_pend || (hyst_time <= T_W'(render))) begin
            if (hold_count < HOLD_MAX) hold_count <= hold_count + 1'b1;
          end else begin
            pend_pat   <= new_pat;
            pend_len   <= new_len;
            hold_count <= HOLD_W'(1);
          end
        end
        S_HOLD2: begin
          if (mul_p >= P_W'(hyst_time)) begin
            active_pat <= new_pat;
            active_len <= new_len;
          end
        end
        default: ;
      endcase
    end
  end

  // Update operands, search scratch and output payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          render <= (s_axis_tdata[TIME_W-1:0] == '0) ? TIME_W'(1)
                                                     : s_axis_tdata[TIME_W-1:0];
          frame  <= s_axis_tdata[2*TIME_W-1:TIME_W];
          dev    <= s_axis_tdata[3*TIME_W-1:2*TIME_W];
          drift  <= s_axis_tdata[4*TIME_W-1:3*TIME_W];
        end
      end
      S_PRE: begin
        jumped  <= jump_now;
        changed <= var_next && (active_len != '0);
      end
      S_CWAIT: begin
        if (div_rsp.done) begin
          cad     <= (div_rsp.quot == '0) ? TIME_W'(1) : div_rsp.quot[TIME_W-1:0];
          new_pat <= '0;
          new_len <= '0;
          n       <= LEN_W'(1);
          best_n  <= '0;
          if ((T_W+1)'(drift) >= (T_W+1)'(min_drift_time)) begin
            new_pat[0] <= sat_entry((K_W+1)'((div_rsp.quot == '0) ? DIV_W'(1)
                                                                 : div_rsp.quot));
            new_len    <= LEN_W'(1);
          end
        end
      end
      S_NFT:   nf <= mul_p[K_W-1:0];
      S_LO:    nft <= mul_p[DIV_W-1:0];
      S_LOW:   if (div_rsp.done) lo <= div_rsp.quot;
      S_KW:    if (div_rsp.done) k <= div_rsp.quot[K_W-1:0];
      S_EN: begin
        err <= err_now[TIME_W-1:0];
        if (best_n == '0 || (k != '0 && best_inf)) begin
          best_n   <= n;
          best_k   <= k;
          best_err <= err_now[TIME_W-1:0];
          best_inf <= (k == '0);
        end
      end
      S_E2:    lhs <= mul_p * P_W'(ERR_SCALE);
      S_E3: begin
        if (lhs < mul_p * P_W'(ERR_KEEP)) begin
          best_n   <= n;
          best_k   <= k;
          best_err <= err;
          best_inf <= 1'b0;
        end
      end
      S_NEXT:  n <= n + 1'b1;
      S_FB2:   fb_err <= TIME_W'(abs_diff(mul_p, P_W'(frame)));
      S_FB3:   lhs <= mul_p;
      S_FB4: begin
        if (lhs >= mul_p) begin
          new_pat[0] <= sat_entry((K_W+1)'(cad));
          new_len    <= LEN_W'(1);
        end
      end
      S_QW:    if (div_rsp.done) q <= div_rsp.quot[K_W-1:0];
      S_QN2: begin
        qn  <= mul_p[K_W-1:0];
        thr <= (K_W+2)'({mul_p[K_W-1:0], 1'b0}) + (K_W+2)'(best_n);
        idx <= '0;
        tgt <= '0;
        acc <= '0;
        new_len <= best_n;
      end
      S_EXP: begin
        new_pat[idx] <= sat_entry(entry_val);
        tgt <= tgt_next;
        acc <= acc + ACC_W'(qn) + (plus ? ACC_W'(best_n) : ACC_W'(0));
        idx <= idx + 1'b1;
      end
      S_CMP: begin
        changed <= !same_active && jumped;
      end
      S_HOLD2: begin
        changed <= (mul_p >= P_W'(hyst_time));
      end
      S_DONE: begin
        if (out_free) begin
          m_axis_tdata <= OUT_TDATA_W'({active_pat, active_len});
          m_axis_tuser <= changed;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Result length never exceeds the longest pattern
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[LEN_W-1:0] <= LEN_W'(MAX_LEN)))
    else $error("pattern length out of range");

  // An accepted update starts the sequence
  assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_PRE))
    else $error("update accepted outside idle");

  // The divider is only started when free
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A finished update with a free output register presents its result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("result not presented");
`endif

endmodule

/* hw/rtl/vce_mul.sv */
// Shared registered multiplier of the cadence estimator.
module vce_mul import vce_pkg::*; (
  input  logic               clk,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [P_W-1:0]     p
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    p <= P_W'(a) * P_W'(b);
  end

endmodule

/* hw/rtl/vce_div.sv */
// Restoring divider of the cadence estimator, one quotient bit per cycle.
module vce_div import vce_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] den;
  logic [DIV_W:0]   trial;
  logic             ge;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quo[DIV_W-1]};
  assign ge    = trial >= {1'b0, den};

  // Control: busy flag, bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.num;
      den <= req.den;
    end else if (busy) begin
      rem <= ge ? DIV_W'(trial - {1'b0, den}) : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quo;

endmodule
